>>> design/sphere_collision_pair_finder_macros.svh
// Assertion macros for the sphere collision pair finder.
// Taken in by the top level; depends on nothing else.
`ifndef SPHERE_COLLISION_PAIR_FINDER_MACROS_SVH
`define SPHERE_COLLISION_PAIR_FINDER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SCPF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SCPF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/scpf_pkg.sv
// Shared types, constants and arithmetic helpers for the sphere collision
// pair finder. No dependencies.
package scpf_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;

    localparam int ID_W    = 31;
    localparam int VAL_W   = 32;
    localparam int DIFF_W  = VAL_W + 1;     // magnitude of a difference or sum
    localparam int SQ_W    = 2 * VAL_W + 2; // square of a DIFF_W magnitude
    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 2;

    // One stored particle
    typedef struct packed {
        logic [VAL_W-1:0] pz;
        logic [VAL_W-1:0] py;
        logic [VAL_W-1:0] px;
        logic [VAL_W-1:0] radius;
        logic [VAL_W-1:0] mass;
        logic [ID_W-1:0]  id;
    } rec_t;

    // |a - b| of two signed 32-bit values; fits 33 bits unsigned
    function automatic logic [DIFF_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        logic [DIFF_W-1:0] d;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    endfunction

    // Exact square of a 33-bit magnitude h*2^32 + l: l^2, plus 2^33*l + 2^64 when h is set
    function automatic logic [SQ_W-1:0] square33(input logic [DIFF_W-1:0] a);
        logic [2*VAL_W-1:0] p;
        logic [SQ_W-1:0]    s;
        p = {{VAL_W{1'b0}}, a[VAL_W-1:0]} * {{VAL_W{1'b0}}, a[VAL_W-1:0]};
        s = {2'b00, p};
        if (a[DIFF_W-1]) begin
            s = s + {1'b0, a[VAL_W-1:0], {(VAL_W+1){1'b0}}} + {2'b01, {(2*VAL_W){1'b0}}};
        end
        return s;
    endfunction

endpackage

>>> design/sphere_collision_pair_finder.sv
// Sphere collision pair finder: loads particles into one record memory and
// scans all pairs for the first overlap. Depends on scpf_pkg and the macros header.
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid / s_axis_tready    tdata: particle, tlast: last particle
//   m_axis    out  m_axis_tvalid / m_axis_tready    tdata: ids, tuser: flags
//
// Loading takes one beat per cycle; each beat writes one record into the memory
// until it is full, and later beats are dropped and flagged as overflow.
// A batch of n particles is scanned with one memory read per pair: for each i,
// one read fetches particle i and S_LATCH_I latches it, then j = i+1..n-1 issue
// one per cycle; the pipeline then drains, and the scan stops as soon as the first overlap leaves it.
// Reset clears the count, the drop flag and the pipeline; the memory is not cleared.
// Input is refused from the last beat until the result beat has been taken.
`include "sphere_collision_pair_finder_macros.svh"

module sphere_collision_pair_finder #(
    parameter int MAX_PARTICLES = scpf_pkg::MAX_PARTICLES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // particle_id, particle_mass, particle_radius, pos_x, pos_y, pos_z, zero pad
    input  logic [scpf_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,   // last_particle
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // primary_id, secondary_id, zero pad
    output logic [scpf_pkg::M_DATA_W-1:0] m_axis_tdata,
    // collision_found, overflow
    output logic [scpf_pkg::M_USER_W-1:0] m_axis_tuser
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int IW = scpf_pkg::ID_W;
    localparam int DW = scpf_pkg::DIFF_W;
    localparam int QW = scpf_pkg::SQ_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH_I,
        S_LATCH_I,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic                 dropped_reg;
    logic [AW-1:0]        i_reg;
    logic [AW-1:0]        j_reg;
    logic [AW-1:0]        rd_addr;
    scpf_pkg::rec_t       rd_data_reg;
    scpf_pkg::rec_t       rec_i_reg;
    scpf_pkg::rec_t       in_rec;
    scpf_pkg::rec_t       mem [MAX_PARTICLES];

    logic                 m_valid_reg;
    logic                 found_reg;
    logic                 ovf_reg;
    logic [IW-1:0]        prim_reg;
    logic [IW-1:0]        sec_reg;

    // pipeline: v0 read data, A diffs, B squares, C partial sum, D compare
    logic                 v0_reg, va_reg, vb_reg, vc_reg, vd_reg;
    logic [DW-1:0]        dx_a_reg, dy_a_reg, dz_a_reg, rs_a_reg;
    logic [IW-1:0]        prim_a_reg, sec_a_reg;
    logic [QW-1:0]        sx_b_reg, sy_b_reg, sz_b_reg, sr_b_reg;
    logic [IW-1:0]        prim_b_reg, sec_b_reg;
    logic [QW:0]          sxy_c_reg;
    logic [QW-1:0]        sz_c_reg, sr_c_reg;
    logic [IW-1:0]        prim_c_reg, sec_c_reg;
    logic                 hit_d_reg;
    logic [IW-1:0]        prim_d_reg, sec_d_reg;

    logic                 s_fire;
    logic                 m_fire;
    logic                 full;
    logic [CW-1:0]        count_next;
    logic                 issue;
    logic                 pipe_hit;
    logic                 pipe_idle;
    logic                 j_last;
    logic                 i_more;
    logic [QW+1:0]        d2_sum;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = m_valid_reg && m_axis_tready;
    assign full          = (count_reg == CW'(MAX_PARTICLES));
    assign count_next    = full ? count_reg : count_reg + CW'(1);

    assign in_rec.id     = s_axis_tdata[30:0];
    assign in_rec.mass   = s_axis_tdata[62:31];
    assign in_rec.radius = s_axis_tdata[94:63];
    assign in_rec.px     = s_axis_tdata[126:95];
    assign in_rec.py     = s_axis_tdata[158:127];
    assign in_rec.pz     = s_axis_tdata[190:159];

    assign issue     = (state_reg == S_SCAN) && !pipe_hit;
    assign pipe_hit  = vd_reg && hit_d_reg;
    assign pipe_idle = !v0_reg && !va_reg && !vb_reg && !vc_reg;
    assign j_last    = ({{(CW-AW){1'b0}}, j_reg} + CW'(1)) == count_reg;
    assign i_more    = ({{(CW-AW){1'b0}}, i_reg} + CW'(2)) < count_reg;
    assign rd_addr   = (state_reg == S_FETCH_I) ? i_reg : j_reg;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(scpf_pkg::M_DATA_W - 2*IW){1'b0}}, sec_reg, prim_reg};
    assign m_axis_tuser  = {ovf_reg, found_reg};

    // record memory: one write port for loading, one registered read port
    always_ff @(posedge aclk) begin
        if (s_fire && !full) begin
            mem[count_reg[AW-1:0]] <= in_rec;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer with load count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_LOAD: begin
                    if (s_fire) begin
                        if (s_axis_tlast && count_next < CW'(2)) begin
                            // fewer than two particles: report no pair at once
                            found_reg   <= 1'b0;
                            prim_reg    <= '0;
                            sec_reg     <= '0;
                            ovf_reg     <= dropped_reg || full;
                            m_valid_reg <= 1'b1;
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= S_RESULT;
                        end else begin
                            count_reg <= count_next;
                            if (full) begin
                                dropped_reg <= 1'b1;
                            end
                            if (s_axis_tlast) begin
                                i_reg     <= '0;
                                state_reg <= S_FETCH_I;
                            end
                        end
                    end
                end
                S_FETCH_I, S_LATCH_I, S_SCAN, S_DRAIN: begin
                    priority if (pipe_hit) begin
                        found_reg   <= 1'b1;
                        prim_reg    <= prim_d_reg;
                        sec_reg     <= sec_d_reg;
                        ovf_reg     <= dropped_reg;
                        m_valid_reg <= 1'b1;
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= S_RESULT;
                    end else if (state_reg == S_FETCH_I) begin
                        j_reg     <= i_reg + AW'(1);
                        state_reg <= S_LATCH_I;
                    end else if (state_reg == S_LATCH_I) begin
                        rec_i_reg <= rd_data_reg;
                        state_reg <= S_SCAN;
                    end else if (state_reg == S_SCAN) begin
                        j_reg <= j_reg + AW'(1);
                        if (j_last) begin
                            i_reg     <= i_reg + AW'(1);
                            state_reg <= i_more ? S_FETCH_I : S_DRAIN;
                        end
                    end else begin
                        if (pipe_idle) begin
                            found_reg   <= 1'b0;
                            prim_reg    <= '0;
                            sec_reg     <= '0;
                            ovf_reg     <= dropped_reg;
                            m_valid_reg <= 1'b1;
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= S_RESULT;
                        end
                    end
                end
                S_RESULT: begin
                    if (m_fire) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_LOAD;
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // pair pipeline valids; flush on the first hit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            v0_reg <= issue;
            va_reg <= v0_reg && !pipe_hit;
            vb_reg <= va_reg && !pipe_hit;
            vc_reg <= vb_reg && !pipe_hit;
            vd_reg <= vc_reg && !pipe_hit;
        end
    end

    assign d2_sum = {1'b0, sxy_c_reg} + {2'b00, sz_c_reg};

    // pair pipeline payload
    always_ff @(posedge aclk) begin
        dx_a_reg <= scpf_pkg::abs_diff(rec_i_reg.px, rd_data_reg.px);
        dy_a_reg <= scpf_pkg::abs_diff(rec_i_reg.py, rd_data_reg.py);
        dz_a_reg <= scpf_pkg::abs_diff(rec_i_reg.pz, rd_data_reg.pz);
        rs_a_reg <= {1'b0, rec_i_reg.radius} + {1'b0, rd_data_reg.radius};
        // heavier is primary; on a tie the earlier particle wins
        if (rec_i_reg.mass >= rd_data_reg.mass) begin
            prim_a_reg <= rec_i_reg.id;
            sec_a_reg  <= rd_data_reg.id;
        end else begin
            prim_a_reg <= rd_data_reg.id;
            sec_a_reg  <= rec_i_reg.id;
        end

        sx_b_reg   <= scpf_pkg::square33(dx_a_reg);
        sy_b_reg   <= scpf_pkg::square33(dy_a_reg);
        sz_b_reg   <= scpf_pkg::square33(dz_a_reg);
        sr_b_reg   <= scpf_pkg::square33(rs_a_reg);
        prim_b_reg <= prim_a_reg;
        sec_b_reg  <= sec_a_reg;

        sxy_c_reg  <= {1'b0, sx_b_reg} + {1'b0, sy_b_reg};
        sz_c_reg   <= sz_b_reg;
        sr_c_reg   <= sr_b_reg;
        prim_c_reg <= prim_b_reg;
        sec_c_reg  <= sec_b_reg;

        hit_d_reg  <= d2_sum <= {2'b00, sr_c_reg};
        prim_d_reg <= prim_c_reg;
        sec_d_reg  <= sec_c_reg;
    end

    `SCPF_ASSERT_IMP(a_no_load_during_result, aclk, aresetn, m_axis_tvalid,
        !s_axis_tready, "input accepted while a result is pending")
    `SCPF_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CW'(MAX_PARTICLES), "particle count exceeds capacity")
    `SCPF_ASSERT_IMP(a_scan_order, aclk, aresetn, state_reg == S_SCAN,
        j_reg > i_reg, "scan pair out of order")
    `SCPF_ASSERT_NXT(a_hit_reports, aclk, aresetn, pipe_hit && !m_valid_reg,
        m_axis_tvalid && m_axis_tuser[0], "overlap not reported")

endmodule
